[rtl/nlss_pkg.sv]
// Package for the node load score sorter: payload structs, list sizes,
// load thresholds and the sequencer state type. No dependencies.
package nlss_pkg;

    localparam int LIST_DEPTH = 32;
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int IDX_W = $clog2(LIST_DEPTH);
    localparam int SCORE_W = 40;

    localparam logic [6:0] HI_LOW = 7'd80;
    localparam logic [6:0] HI_HIGH = 7'd90;
    localparam logic [6:0] BW_LOW = 7'd30;
    localparam logic [6:0] BW_HIGH = 7'd80;
    localparam logic [5:0] PTS_MID = 6'd10;
    localparam logic [5:0] PTS_TOP = 6'd50;
    localparam logic [14:0] SCALE = 15'd25600;

    typedef struct packed {
        logic        first_node;
        logic        last_node;
        logic [7:0]  node_id;
        logic [6:0]  cpu_usage;
        logic [6:0]  mem_usage;
        logic [6:0]  disk_usage;
        logic [6:0]  bw_usage;
        logic [11:0] vnode_total;
        logic [11:0] vnode_free;
        logic [7:0]  extra_vnodes;
        logic        has_mgmt_module;
        logic signed [15:0] custom_score;
    } in_item_t;

    typedef struct packed {
        logic        result_type;
        logic [7:0]  out_node_id;
        logic signed [39:0] score;
        logic [4:0]  position;
        logic        list_full;
        logic        last_result;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DIV1, ST_DIV2, ST_SCAN, ST_REPORT, ST_LIST
    } state_t;

    // Divider handshake from the sequencer.
    typedef struct packed {
        logic        start;
        logic [26:0] dividend;
        logic [11:0] divisor;
    } div_req_t;

    function automatic logic [5:0] load_points(input logic [6:0] u,
                                               input logic [6:0] lo,
                                               input logic [6:0] hi);
        if (u < lo) return 6'd0;
        if (u < hi) return PTS_MID;
        return PTS_TOP;
    endfunction

endpackage

[rtl/nlss_divider.sv]
// Restoring bit-serial divider: one quotient bit per cycle.
// Depends on nlss_pkg for the request struct.
module nlss_divider
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  nlss_pkg::div_req_t       req,
    output logic                     done,
    output logic [26:0]              quotient
);

    logic [26:0] quo_reg, quo_next;
    logic [12:0] rem_reg, rem_next;
    logic [11:0] dvs_reg, dvs_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [12:0] trial;

    // One shift and subtract step per cycle.
    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {rem_reg[11:0], quo_reg[26]};
        if (req.start)
        begin
            quo_next = req.dividend;
            rem_next = '0;
            dvs_next = req.divisor;
            cnt_next = 5'd26;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = trial - {1'b0, dvs_reg};
                quo_next = {quo_reg[25:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[25:0], 1'b0};
            end
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done = done_reg;
    assign quotient = quo_reg;

endmodule

[rtl/node_load_score_sorter.sv]
// Top level of the node load score sorter: scoring sequencer, sorted list
// memory and output register. Depends on nlss_pkg and nlss_divider.
//
// channel   direction  handshake        payload
// in        input      in_valid/stall   nlss_pkg::in_item_t
// out       output     out_valid/stall  nlss_pkg::out_item_t
// cfg       input      valid/ready      equal_vnodes_mgmt, 12 bits
//
// An item takes two serial divisions to set the score, then the list is
// walked from the top to shift entries not below the new score up; a
// last item then reports every list entry in turn.
// Reset clears the count, the state and the register; list contents are
// undefined. An output stall holds the sequencer until the item is taken.
module node_load_score_sorter
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  nlss_pkg::in_item_t    in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output nlss_pkg::out_item_t   out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [11:0]           cfg_data
);

    nlss_pkg::state_t state_reg, state_next;
    nlss_pkg::in_item_t item_reg;
    logic [11:0] eqv_reg;
    logic [nlss_pkg::CNT_W-1:0] count_reg, count_next;
    logic [nlss_pkg::CNT_W-1:0] idx_reg, idx_next;
    logic signed [nlss_pkg::SCORE_W-1:0] score_reg, score_next;
    logic        ovalid_reg;
    nlss_pkg::out_item_t odata_reg;
    logic [47:0] mem [nlss_pkg::LIST_DEPTH];
    logic [47:0] rd_reg;
    logic        rd_ok_reg;
    logic        div_done;
    logic [26:0] quotient;
    nlss_pkg::div_req_t dreq;
    logic        accept, can_out;
    logic        small_tot;
    logic signed [14:0] vshare;
    logic        vneg;

    assign accept = in_valid && !in_stall;
    assign can_out = !ovalid_reg || !out_stall;
    assign in_stall = (state_reg != nlss_pkg::ST_IDLE) || ovalid_reg;
    assign cfg_ready = 1'b1;
    assign small_tot = item_reg.vnode_total <= 12'd1;
    assign vshare = $signed({3'b000, item_reg.vnode_total})
                    - $signed({3'b000, item_reg.vnode_free})
                    + $signed({7'd0, item_reg.extra_vnodes});
    assign vneg = vshare[14];

    nlss_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (dreq),
        .done     (div_done),
        .quotient (quotient)
    );

    // Divider requests: module share, then magnitude of the vnode share.
    always_comb
    begin
        logic [14:0] vmag;
        vmag = vneg ? 15'(-vshare) : 15'(vshare);
        dreq.divisor = item_reg.vnode_total;
        dreq.start = 1'b0;
        dreq.dividend = 27'(eqv_reg) * 27'(nlss_pkg::SCALE);
        if (state_reg == nlss_pkg::ST_IDLE && accept)
        begin
            dreq.divisor = in_data.vnode_total;
            dreq.dividend = 27'(eqv_reg) * 27'(nlss_pkg::SCALE);
            dreq.start = 1'b1;
        end
        else if (state_reg == nlss_pkg::ST_DIV1 && div_done)
        begin
            dreq.dividend = 27'(vmag) * 27'(nlss_pkg::SCALE);
            dreq.start = 1'b1;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            nlss_pkg::ST_IDLE:   if (accept) state_next = nlss_pkg::ST_DIV1;
            nlss_pkg::ST_DIV1:   if (div_done) state_next = nlss_pkg::ST_DIV2;
            nlss_pkg::ST_DIV2:   if (div_done) state_next = nlss_pkg::ST_SCAN;
            nlss_pkg::ST_SCAN:
                if (count_reg == nlss_pkg::CNT_W'(nlss_pkg::LIST_DEPTH)
                    || idx_reg == '0 || (rd_ok_reg && score_reg > $signed(rd_reg[39:0])))
                    state_next = nlss_pkg::ST_REPORT;
            nlss_pkg::ST_REPORT:
                if (can_out)
                    state_next = (item_reg.last_node && count_next != '0)
                                 ? nlss_pkg::ST_LIST : nlss_pkg::ST_IDLE;
            nlss_pkg::ST_LIST:
                if (can_out && rd_ok_reg && idx_reg + 1'b1 == count_reg)
                    state_next = nlss_pkg::ST_IDLE;
            default: state_next = nlss_pkg::ST_IDLE;
        endcase
    end

    function automatic logic signed [39:0] SCORE_W_ext(input logic [5:0] p);
        return $signed({34'd0, p});
    endfunction

    // Datapath controls and list updates.
    always_comb
    begin
        count_next = count_reg;
        idx_next = idx_reg;
        score_next = score_reg;
        case (state_reg)
            nlss_pkg::ST_IDLE:
                if (accept)
                begin
                    if (in_data.first_node) count_next = '0;
                    score_next = (SCORE_W_ext(nlss_pkg::load_points(in_data.cpu_usage,
                                 nlss_pkg::HI_LOW, nlss_pkg::HI_HIGH))
                                 + SCORE_W_ext(nlss_pkg::load_points(in_data.mem_usage,
                                 nlss_pkg::HI_LOW, nlss_pkg::HI_HIGH))
                                 + SCORE_W_ext(nlss_pkg::load_points(in_data.disk_usage,
                                 nlss_pkg::HI_LOW, nlss_pkg::HI_HIGH))
                                 + SCORE_W_ext(nlss_pkg::load_points(in_data.bw_usage,
                                 nlss_pkg::BW_LOW, nlss_pkg::BW_HIGH))
                                 + 40'(in_data.custom_score)) <<< 8;
                end
            nlss_pkg::ST_DIV1:
                if (div_done && !small_tot && item_reg.has_mgmt_module)
                    score_next = score_reg + $signed({13'd0, quotient});
            nlss_pkg::ST_DIV2:
                if (div_done)
                begin
                    if (!small_tot)
                        score_next = vneg ? score_reg - $signed({13'd0, quotient})
                                          : score_reg + $signed({13'd0, quotient});
                    idx_next = count_reg;
                end
            nlss_pkg::ST_SCAN:
                if (!(count_reg == nlss_pkg::CNT_W'(nlss_pkg::LIST_DEPTH) || idx_reg == '0
                      || (rd_ok_reg && score_reg > $signed(rd_reg[39:0]))) && rd_ok_reg)
                    idx_next = idx_reg - 1'b1;
            nlss_pkg::ST_REPORT:
                if (can_out)
                begin
                    if (count_reg != nlss_pkg::CNT_W'(nlss_pkg::LIST_DEPTH))
                        count_next = count_reg + 1'b1;
                    idx_next = '0;
                end
            nlss_pkg::ST_LIST:
                if (can_out && rd_ok_reg) idx_next = idx_reg + 1'b1;
            default: ;
        endcase
    end

    // List memory: read at idx-1 while scanning, idx while listing; the
    // scan writes each entry not below the new score one place up.
    always_ff @(posedge clk)
    begin
        rd_ok_reg <= 1'b0;
        if (state_reg == nlss_pkg::ST_SCAN && state_next == nlss_pkg::ST_SCAN)
        begin
            if (rd_ok_reg)
            begin
                mem[idx_reg[nlss_pkg::IDX_W-1:0]] <= rd_reg;
            end
            else
            begin
                rd_reg <= mem[nlss_pkg::IDX_W'(idx_reg - 1'b1)];
                rd_ok_reg <= 1'b1;
            end
        end
        else if (state_reg == nlss_pkg::ST_REPORT && can_out
                 && count_reg != nlss_pkg::CNT_W'(nlss_pkg::LIST_DEPTH))
        begin
            mem[idx_reg[nlss_pkg::IDX_W-1:0]] <= {item_reg.node_id, score_reg};
        end
        else if (state_reg == nlss_pkg::ST_LIST)
        begin
            if (!rd_ok_reg)
            begin
                rd_reg <= mem[idx_reg[nlss_pkg::IDX_W-1:0]];
                rd_ok_reg <= 1'b1;
            end
            else if (!can_out)
            begin
                rd_ok_reg <= 1'b1;
            end
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (state_reg == nlss_pkg::ST_REPORT && can_out)
        begin
            odata_reg.result_type <= 1'b0;
            odata_reg.out_node_id <= item_reg.node_id;
            odata_reg.score <= score_reg;
            odata_reg.list_full <= count_reg == nlss_pkg::CNT_W'(nlss_pkg::LIST_DEPTH);
            odata_reg.position <= (count_reg == nlss_pkg::CNT_W'(nlss_pkg::LIST_DEPTH))
                                  ? 5'd0 : 5'(idx_reg);
            odata_reg.last_result <= !(item_reg.last_node && count_next != '0);
        end
        else if (state_reg == nlss_pkg::ST_LIST && can_out && rd_ok_reg)
        begin
            odata_reg.result_type <= 1'b1;
            odata_reg.out_node_id <= rd_reg[47:40];
            odata_reg.score <= $signed(rd_reg[39:0]);
            odata_reg.position <= 5'(idx_reg);
            odata_reg.list_full <= 1'b0;
            odata_reg.last_result <= idx_reg + 1'b1 == count_reg;
        end
        if (accept) item_reg <= in_data;
        score_reg <= score_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nlss_pkg::ST_IDLE;
            count_reg <= '0;
            idx_reg <= '0;
            ovalid_reg <= 1'b0;
            eqv_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg <= idx_next;
            if (cfg_valid) eqv_reg <= cfg_data;
            if ((state_reg == nlss_pkg::ST_REPORT && can_out)
                || (state_reg == nlss_pkg::ST_LIST && can_out && rd_ok_reg))
                ovalid_reg <= 1'b1;
            else if (!out_stall)
                ovalid_reg <= 1'b0;
        end
    end

    assign out_valid = ovalid_reg;
    assign out_data = odata_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= nlss_pkg::CNT_W'(nlss_pkg::LIST_DEPTH))
        else $error("list count above depth");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != nlss_pkg::ST_IDLE) |-> !accept)
        else $error("item accepted while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("stalled output changed");

endmodule

[tb/node_load_score_sorter_tb.sv]
`timescale 1ns / 100ps
// Testbench for the node load score sorter: drives node load reports with
// random bursts and gaps, predicts scores and sorted lists, checks each result.
// Depends on nlss_pkg and the node_load_score_sorter RTL.
module node_load_score_sorter_tb;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    nlss_pkg::in_item_t    in_data;
    logic        out_valid;
    logic        out_stall = 1'b0;
    nlss_pkg::out_item_t   out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [11:0] cfg_data;

    // Predictor state: register copy and the sorted list.
    logic [11:0]        mgmt_vnodes;
    logic [7:0]         list_id [nlss_pkg::LIST_DEPTH];
    logic signed [39:0] list_score [nlss_pkg::LIST_DEPTH];
    int                 list_count;
    nlss_pkg::out_item_t expected_q [$];
    int                 fail_count;
    bit                 stall_mode = 1'b0;

    node_load_score_sorter uut
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    initial
    begin
        #400ms;
        $display("Regression FAIL");
        $finish;
    end

    function automatic int usage_points(int u, int lo, int hi);
        if (u < lo)
            return 0;
        if (u < hi)
            return 10;
        return 50;
    endfunction

    // Compute the score of one report, insert it and queue its results.
    task automatic predict_node(input nlss_pkg::in_item_t it);
        longint     sc;
        longint     total;
        int         pos;
        nlss_pkg::out_item_t r;
        if (it.first_node)
            list_count = 0;
        sc = usage_points(it.cpu_usage, 80, 90) + usage_points(it.mem_usage, 80, 90)
            + usage_points(it.disk_usage, 80, 90) + usage_points(it.bw_usage, 30, 80);
        sc = sc * 256 + longint'(it.custom_score) * 256;
        total = it.vnode_total;
        if (total > 1)
        begin
            if (it.has_mgmt_module)
                sc += (longint'(mgmt_vnodes) * 25600) / total;
            sc += ((total - longint'(it.vnode_free) + longint'(it.extra_vnodes)) * 25600)
                / total;
        end
        r = '0;
        r.out_node_id = it.node_id;
        r.score = sc[39:0];
        if (list_count < nlss_pkg::LIST_DEPTH)
        begin
            pos = list_count;
            while (pos > 0 && !(sc > longint'(list_score[pos-1])))
            begin
                list_score[pos] = list_score[pos-1];
                list_id[pos] = list_id[pos-1];
                pos--;
            end
            list_score[pos] = sc[39:0];
            list_id[pos] = it.node_id;
            list_count++;
            r.position = pos[4:0];
        end
        else
        begin
            r.list_full = 1'b1;
        end
        r.last_result = !it.last_node;
        expected_q.push_back(r);
        if (it.last_node)
        begin
            for (int i = 0; i < list_count; i++)
            begin
                r = '0;
                r.result_type = 1'b1;
                r.out_node_id = list_id[i];
                r.score = list_score[i];
                r.position = i[4:0];
                r.last_result = (i == list_count - 1);
                expected_q.push_back(r);
            end
        end
    endtask

    // Send one item, then hold valid low for a random gap now and then.
    task automatic send_node(input nlss_pkg::in_item_t it);
        in_valid <= 1'b1;
        in_data <= it;
        predict_node(it);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if ($urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12))
                @(posedge clk);
        end
    endtask

    function automatic nlss_pkg::in_item_t random_node(bit first, bit last);
        nlss_pkg::in_item_t it;
        logic [95:0] rnd;
        rnd = {$urandom, $urandom, $urandom};
        it = rnd[$bits(nlss_pkg::in_item_t)-1:0];
        it.first_node = first;
        it.last_node = last;
        case ($urandom_range(0, 3))
            0: it.vnode_total = 12'($urandom_range(0, 3));
            1: it.vnode_total = 12'($urandom_range(2, 40));
            default: ;
        endcase
        if ($urandom_range(0, 2) != 0)
        begin
            it.vnode_free = 12'($urandom_range(0, it.vnode_total));
            it.extra_vnodes = $urandom_range(0, 1) ? 8'd0 : it.extra_vnodes;
        end
        if ($urandom_range(0, 2) == 0)
            it.custom_score = 16'(int'($urandom_range(0, 4)) - 2);
        return it;
    endfunction

    // Wait until every result is in, then let the block settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (150)
            @(posedge clk);
    endtask

    task automatic write_mgmt_vnodes(input logic [11:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        mgmt_vnodes = value;
    endtask

    // Receiver stall pattern: stretches with no stalls alternate with
    // stretches of random stalls.
    always @(posedge clk)
    begin
        if ($urandom_range(0, 199) == 0)
            stall_mode <= ~stall_mode;
        out_stall <= stall_mode ? ($urandom_range(0, 2) == 0) : 1'b0;
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        nlss_pkg::out_item_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                $error("unexpected result, node %0d", out_data.out_node_id);
                fail_count++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (out_data.result_type !== e.result_type)
                begin
                    $error("result_type exp %0d got %0d", e.result_type, out_data.result_type);
                    fail_count++;
                end
                if (out_data.out_node_id !== e.out_node_id)
                begin
                    $error("out_node_id exp %0d got %0d", e.out_node_id, out_data.out_node_id);
                    fail_count++;
                end
                if (out_data.score !== e.score)
                begin
                    $error("score exp %0d got %0d", e.score, out_data.score);
                    fail_count++;
                end
                if (out_data.position !== e.position)
                begin
                    $error("position exp %0d got %0d", e.position, out_data.position);
                    fail_count++;
                end
                if (out_data.list_full !== e.list_full)
                begin
                    $error("list_full exp %0d got %0d", e.list_full, out_data.list_full);
                    fail_count++;
                end
                if (out_data.last_result !== e.last_result)
                begin
                    $error("last_result exp %0d got %0d", e.last_result, out_data.last_result);
                    fail_count++;
                end
            end
        end
    end

    // Thresholds, vnode extremes, custom score extremes and ties.
    task automatic test_directed();
        nlss_pkg::in_item_t it;
        int u [6] = '{0, 29, 30, 79, 80, 127};
        for (int i = 0; i < 6; i++)
        begin
            it = '0;
            it.first_node = (i == 0);
            it.node_id = 8'(i);
            it.cpu_usage = 7'(u[i]);
            it.mem_usage = (i == 5) ? 7'd90 : 7'd89;
            it.disk_usage = 7'(u[5-i]);
            it.bw_usage = 7'(u[i]);
            it.vnode_total = 12'(i);
            it.vnode_free = 12'(4095 - i);
            it.extra_vnodes = (i == 5) ? 8'hff : 8'h00;
            it.has_mgmt_module = i[0];
            it.custom_score = (i == 4) ? -16'sd32768 : (i == 5 ? 16'sd32767 : 16'sd0);
            send_node(it);
        end
        // Equal scores go ahead of existing ties; a small negative vnode share.
        for (int i = 0; i < 5; i++)
        begin
            it = '0;
            it.node_id = 8'(100 + i);
            it.vnode_total = 12'd3;
            it.vnode_free = (i == 4) ? 12'd4 : 12'd1;
            it.has_mgmt_module = 1'b1;
            it.custom_score = (i == 4) ? 16'sd0 : 16'sd0;
            it.last_node = (i == 4);
            send_node(it);
        end
        it = '1;
        it.first_node = 1'b1;
        send_node(it);
    endtask

    // Fill the list beyond its depth so late nodes are dropped.
    task automatic test_list_full();
        for (int i = 0; i < nlss_pkg::LIST_DEPTH + 4; i++)
            send_node(random_node(i == 0, i == nlss_pkg::LIST_DEPTH + 3));
    endtask

    // Random well-formed rounds of random length, with stray noise.
    task automatic test_random_rounds(input int items);
        int sent;
        int len;
        sent = 0;
        while (sent < items)
        begin
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
                send_node(random_node(i == 0, i == len - 1));
            sent += len;
            if ($urandom_range(0, 4) == 0)
            begin
                send_node(random_node(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        mgmt_vnodes = '0;
        list_count = 0;
        fail_count = 0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        drain();
        write_mgmt_vnodes(12'd4095);
        test_directed();
        test_list_full();
        drain();
        write_mgmt_vnodes(12'd1);
        test_random_rounds(200);
        drain();
        write_mgmt_vnodes(12'd0);
        test_random_rounds(100);
        drain();
        write_mgmt_vnodes(12'($urandom_range(0, 4095)));
        test_random_rounds(100);
        drain();
        if (fail_count == 0 && expected_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
